// ===== hw/rtl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
package hsvrgb_pkg;

  localparam int NUM_W   = 22;
  localparam int RECIP_W = 23;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 36;

  localparam logic [8:0] FULL_TURN = 9'd360;
  localparam logic [8:0] HUE_60    = 9'd60;
  localparam logic [8:0] HUE_120   = 9'd120;
  localparam logic [8:0] HUE_180   = 9'd180;
  localparam logic [8:0] HUE_240   = 9'd240;
  localparam logic [8:0] HUE_300   = 9'd300;

  localparam logic [NUM_W-1:0]   SECTOR_WEIGHT = 22'd60;
  localparam logic [NUM_W-1:0]   SCALE_DEN     = 22'd15300;
  localparam logic [NUM_W-1:0]   HALF_DEN      = 22'd7650;
  localparam logic [NUM_W-1:0]   MAX_ROUNDED   = 22'd3909150;
  localparam logic [RECIP_W-1:0] RECIP_MUL     = 23'd4491470;

  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW,
    SECTOR_YELLOW_GREEN,
    SECTOR_GREEN_CYAN,
    SECTOR_CYAN_BLUE,
    SECTOR_BLUE_MAGENTA,
    SECTOR_MAGENTA_RED
  } sector_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] saturation;
    logic [8:0] hue;
  } pixel_t;

  typedef struct packed {
    sector_t     sector;
    logic [5:0]  k;
    logic [7:0]  v;
    logic [15:0] vs;
  } hue_info_t;

  typedef struct packed {
    logic [NUM_W-1:0] blue;
    logic [NUM_W-1:0] green;
    logic [NUM_W-1:0] red;
  } rgb_num_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

endpackage

// ===== hw/rtl/hsv_to_rgb_pixel_convert.sv =====
// Top level of the HSV to RGB pixel converter stream block.
//
// Converts one HSV pixel per transaction into 8-bit RGB, rounded half up from the exact value
// over the denominator 15300. The block is a four-stage pipeline that takes a new pixel every
// clock while the output is not stalled. Its stages, in order, are the hue stage, the numerator
// stage, the select-and-round stage and the reciprocal-multiply stage, whose register is the
// output register. Each stage holds its own valid bit, so a stalled output only blocks the
// input once every stage is full.
module hsv_to_rgb_pixel_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // hue[8:0], saturation[16:9], brightness[24:17], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // red_out[7:0], green_out[15:8], blue_out[23:16], zero
);

  hsvrgb_pkg::pixel_t    pixel;
  hsvrgb_pkg::hue_info_t hue_info;
  hsvrgb_pkg::rgb_num_t  rgb_num;
  hsvrgb_pkg::rgb_t      rgb;
  logic                  hue_valid;
  logic                  hue_ready;
  logic                  num_valid;
  logic                  num_ready;

  assign pixel = s_axis_tdata[24:0];

  hsvrgb_hue_stage u_hue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (pixel),
    .out_valid (hue_valid),
    .out_ready (hue_ready),
    .out_data  (hue_info)
  );

  hsvrgb_mix_stage u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hue_valid),
    .in_ready  (hue_ready),
    .in_data   (hue_info),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_data  (rgb_num)
  );

  hsvrgb_recip_stage u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_data   (rgb_num),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (rgb)
  );

  assign m_axis_tdata = {8'd0, rgb};

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (hue_valid && num_valid && m_axis_tvalid && !m_axis_tready))
    else $error("Input blocked while the pipeline has a free stage.");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    hue_valid |-> (hue_info.k <= 6'd60))
    else $error("Hue weight out of range.");

  a_rounded_range: assert property (@(posedge clk) disable iff (rst)
    num_valid |-> (rgb_num.red >= hsvrgb_pkg::HALF_DEN && rgb_num.red <= hsvrgb_pkg::MAX_ROUNDED
                && rgb_num.green >= hsvrgb_pkg::HALF_DEN
                && rgb_num.green <= hsvrgb_pkg::MAX_ROUNDED
                && rgb_num.blue >= hsvrgb_pkg::HALF_DEN
                && rgb_num.blue <= hsvrgb_pkg::MAX_ROUNDED))
    else $error("Channel numerator out of range.");
`endif

endmodule

// ===== hw/rtl/hsvrgb_hue_stage.sv =====
// First pipeline stage: hue reduction, sector and weight, saturation times value.
module hsvrgb_hue_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsvrgb_pkg::pixel_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsvrgb_pkg::hue_info_t out_data
);

  localparam logic [6:0] HALF_SPAN = 7'd60;
  localparam logic [6:0] SPAN      = 7'd120;

  logic [8:0]            h;
  logic [8:0]            r_full;
  logic [6:0]            r120;
  hsvrgb_pkg::hue_info_t info_next;

  always_comb begin
    h = (in_data.hue >= hsvrgb_pkg::FULL_TURN) ? (in_data.hue - hsvrgb_pkg::FULL_TURN)
                                               : in_data.hue;
    if (h < hsvrgb_pkg::HUE_60) begin
      info_next.sector = hsvrgb_pkg::SECTOR_RED_YELLOW;
    end else if (h < hsvrgb_pkg::HUE_120) begin
      info_next.sector = hsvrgb_pkg::SECTOR_YELLOW_GREEN;
    end else if (h < hsvrgb_pkg::HUE_180) begin
      info_next.sector = hsvrgb_pkg::SECTOR_GREEN_CYAN;
    end else if (h < hsvrgb_pkg::HUE_240) begin
      info_next.sector = hsvrgb_pkg::SECTOR_CYAN_BLUE;
    end else if (h < hsvrgb_pkg::HUE_300) begin
      info_next.sector = hsvrgb_pkg::SECTOR_BLUE_MAGENTA;
    end else begin
      info_next.sector = hsvrgb_pkg::SECTOR_MAGENTA_RED;
    end
    if (h >= hsvrgb_pkg::HUE_240) begin
      r_full = h - hsvrgb_pkg::HUE_240;
    end else if (h >= hsvrgb_pkg::HUE_120) begin
      r_full = h - hsvrgb_pkg::HUE_120;
    end else begin
      r_full = h;
    end
    r120 = r_full[6:0];
    info_next.k  = (r120 < HALF_SPAN) ? r120[5:0] : 6'(SPAN - r120);
    info_next.v  = in_data.brightness;
    info_next.vs = 16'(in_data.saturation) * 16'(in_data.brightness);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= info_next;
    end
  end

endmodule

// ===== hw/rtl/hsvrgb_mix_stage.sv =====
// Second and third pipeline stages: channel numerators, sector selection and rounding offset.
module hsvrgb_mix_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsvrgb_pkg::hue_info_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsvrgb_pkg::rgb_num_t  out_data
);

  localparam int W = hsvrgb_pkg::NUM_W;

  hsvrgb_pkg::sector_t sector;
  logic [W-1:0]        n_c;
  logic [W-1:0]        n_z;
  logic [W-1:0]        vsk;
  logic                mid_valid;
  logic                mid_ready;

  logic [W-1:0]         n_c_next;
  logic [W-1:0]         n_z_next;
  logic [W-1:0]         vsk_next;
  logic [W-1:0]         n_x;
  hsvrgb_pkg::rgb_num_t num_next;

  always_comb begin
    n_c_next = W'(in_data.v) * hsvrgb_pkg::SCALE_DEN;
    n_z_next = n_c_next - W'(in_data.vs) * hsvrgb_pkg::SECTOR_WEIGHT;
    vsk_next = W'(in_data.vs) * W'(in_data.k);
  end

  assign in_ready  = !mid_valid || mid_ready;
  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sector <= in_data.sector;
      n_c    <= n_c_next;
      n_z    <= n_z_next;
      vsk    <= vsk_next;
    end
  end

  always_comb begin
    n_x = n_z + vsk;
    case (sector)
      hsvrgb_pkg::SECTOR_RED_YELLOW: begin
        num_next.red = n_c; num_next.green = n_x; num_next.blue = n_z;
      end
      hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
        num_next.red = n_x; num_next.green = n_c; num_next.blue = n_z;
      end
      hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
        num_next.red = n_z; num_next.green = n_c; num_next.blue = n_x;
      end
      hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
        num_next.red = n_z; num_next.green = n_x; num_next.blue = n_c;
      end
      hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
        num_next.red = n_x; num_next.green = n_z; num_next.blue = n_c;
      end
      default: begin
        num_next.red = n_c; num_next.green = n_z; num_next.blue = n_x;
      end
    endcase
    num_next.red   = num_next.red + hsvrgb_pkg::HALF_DEN;
    num_next.green = num_next.green + hsvrgb_pkg::HALF_DEN;
    num_next.blue  = num_next.blue + hsvrgb_pkg::HALF_DEN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      out_data <= num_next;
    end
  end

endmodule

// ===== hw/rtl/hsvrgb_recip_stage.sv =====
// Last pipeline stage: division by 15300 through a reciprocal multiply, into the output register.
module hsvrgb_recip_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsvrgb_pkg::rgb_num_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsvrgb_pkg::rgb_t     out_data
);

  localparam int PW = hsvrgb_pkg::PROD_W;
  localparam int SH = hsvrgb_pkg::RECIP_SHIFT;

  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    prod_g;
  logic [PW-1:0]    prod_b;
  hsvrgb_pkg::rgb_t rgb_next;

  always_comb begin
    prod_r = PW'(in_data.red) * PW'(hsvrgb_pkg::RECIP_MUL);
    prod_g = PW'(in_data.green) * PW'(hsvrgb_pkg::RECIP_MUL);
    prod_b = PW'(in_data.blue) * PW'(hsvrgb_pkg::RECIP_MUL);
    rgb_next.red   = prod_r[SH+7:SH];
    rgb_next.green = prod_g[SH+7:SH];
    rgb_next.blue  = prod_b[SH+7:SH];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= rgb_next;
    end
  end

endmodule
